// ===== rtl/core/brb_pkg.sv =====
// Shared types and codes for the block reassembly buffer.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

  // Command codes carried by an input item.
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_HEADER    = 2'd0;
  localparam cmd_t CMD_PAYLOAD   = 2'd1;
  localparam cmd_t CMD_SET_FRAME = 2'd2;
  localparam cmd_t CMD_READ      = 2'd3;

  // Status codes carried by a result item.
  typedef logic [1:0] status_t;
  localparam status_t ST_APPLIED   = 2'd0;
  localparam status_t ST_DUPLICATE = 2'd1;
  localparam status_t ST_REJECTED  = 2'd2;
  localparam status_t ST_ACK       = 2'd3;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_EXEC = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // an input item is taken this cycle
    logic calc;    // register the offset products
    logic exec;    // decide and update the entry state
    logic emit;    // load the result into the output register
  } brb_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // the output register can take a result this cycle
  } brb_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/brb_in_if.sv =====
// Input channel of the block reassembly buffer: valid, ready and one input item.
// Depends on brb_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

interface brb_in_if
  import brb_pkg::*;
;
  logic       valid;
  logic       ready;
  cmd_t       command;
  logic [2:0] entry_index;
  logic [1:0] region_select;
  logic [7:0] frame;
  logic [4:0] block_index;
  logic [5:0] block_count;
  logic [6:0] block_length;
  logic [7:0] data_byte;
  logic [9:0] read_offset;

  modport source (
    output valid, command, entry_index, region_select, frame, block_index,
           block_count, block_length, data_byte, read_offset,
    input  ready
  );

  modport sink (
    input  valid, command, entry_index, region_select, frame, block_index,
           block_count, block_length, data_byte, read_offset,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/brb_out_if.sv =====
// Result channel of the block reassembly buffer: valid, ready and one result item.
// Depends on brb_pkg for the status type.
`timescale 1ns / 1ps
`default_nettype none

interface brb_out_if
  import brb_pkg::*;
;
  logic        valid;
  logic        ready;
  status_t     status;
  logic [31:0] done_mask;
  logic [31:0] valid_mask;
  logic [1:0]  last_region;
  logic [7:0]  read_data;

  modport source (
    output valid, status, done_mask, valid_mask, last_region, read_data,
    input  ready
  );

  modport sink (
    input  valid, status, done_mask, valid_mask, last_region, read_data,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/block_reassembly_buffer.sv =====
// Block reassembly buffer, top level. Wires the controller and datapath to the
// input and result channels. Depends on brb_pkg, brb_in_if, brb_out_if.
`timescale 1ns / 1ps
`default_nettype none

// Each entry owns BUFFER_BYTES bytes of a single-port-write, registered-read
// byte store; a block header opens a block in region 0 or region 1 of an
// entry and the following payload items fill it in order. A payload item is
// taken in the idle state, so payload streams at one item per cycle while no
// other command is in progress. A header, set-frame or read command passes
// through accept, offset multiply, decision and store read, and result load;
// the result load waits while a previous result is still to be taken. The
// byte store has no reset and needs no clearing pass; a read of a byte that
// was never written returns an undefined value.

module block_reassembly_buffer
  import brb_pkg::*;
#(
  parameter int NUM_ENTRIES  = 8,
  parameter int BLOCK_STRIDE = 98,
  parameter int REGION1_BASE = 544,
  parameter int BUFFER_BYTES = 856
) (
  input wire logic clk,
  input wire logic rst_n,
  brb_in_if.sink   in_if,
  brb_out_if.source out_if
);

  brb_ctrl_t ctrl;
  brb_stat_t stat;

  // Sequencer.
  brb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_command (in_if.command),
    .in_ready   (in_if.ready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  // Storage and result path.
  brb_dp #(
    .NUM_ENTRIES  (NUM_ENTRIES),
    .BLOCK_STRIDE (BLOCK_STRIDE),
    .REGION1_BASE (REGION1_BASE),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_command       (in_if.command),
    .in_entry_index   (in_if.entry_index),
    .in_region_select (in_if.region_select),
    .in_frame         (in_if.frame),
    .in_block_index   (in_if.block_index),
    .in_block_count   (in_if.block_count),
    .in_block_length  (in_if.block_length),
    .in_data_byte     (in_if.data_byte),
    .in_read_offset   (in_if.read_offset),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_status       (out_if.status),
    .out_done_mask    (out_if.done_mask),
    .out_valid_mask   (out_if.valid_mask),
    .out_last_region  (out_if.last_region),
    .out_read_data    (out_if.read_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/brb_ctrl.sv =====
// Sequencing state machine of the block reassembly buffer.
// Depends on brb_pkg for the state, command and control types.
`timescale 1ns / 1ps
`default_nettype none

module brb_ctrl
  import brb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire cmd_t      in_command,
  output logic           in_ready,
  input  wire brb_stat_t stat,
  output brb_ctrl_t      ctrl
);

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Payload items finish in the accept cycle; every other command walks
  // through offset calculation, execution and result delivery.
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    unique case (state_r)
      S_IDLE: begin
        ctrl.accept = accept;
        if (accept && (in_command != CMD_PAYLOAD)) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        ctrl.calc = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        ctrl.exec = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/brb_dp.sv =====
// Datapath of the block reassembly buffer: item capture, entry state, byte store
// and output register. Depends on brb_pkg; driven by brb_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module brb_dp
  import brb_pkg::*;
#(
  parameter int NUM_ENTRIES  = 8,
  parameter int BLOCK_STRIDE = 98,
  parameter int REGION1_BASE = 544,
  parameter int BUFFER_BYTES = 856
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire brb_ctrl_t   ctrl,
  output brb_stat_t        stat,
  input  wire cmd_t        in_command,
  input  wire logic [2:0]  in_entry_index,
  input  wire logic [1:0]  in_region_select,
  input  wire logic [7:0]  in_frame,
  input  wire logic [4:0]  in_block_index,
  input  wire logic [5:0]  in_block_count,
  input  wire logic [6:0]  in_block_length,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [9:0]  in_read_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output status_t          out_status,
  output logic [31:0]      out_done_mask,
  output logic [31:0]      out_valid_mask,
  output logic [1:0]       out_last_region,
  output logic [7:0]       out_read_data
);

  localparam int STORE_BYTES = NUM_ENTRIES * BUFFER_BYTES;
  localparam int AW = $clog2(STORE_BYTES);
  localparam int PW = $clog2(STORE_BYTES + 1);
  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int SPAN_MAX = REGION1_BASE + 31 * BLOCK_STRIDE + 127;
  localparam int SW = $clog2(((SPAN_MAX > BUFFER_BYTES) ? SPAN_MAX : BUFFER_BYTES) + 1);

  localparam logic [4:0]    NUM_ENTRIES_X = 5'(NUM_ENTRIES);
  localparam logic [PW-1:0] BUF_BYTES_P   = PW'(BUFFER_BYTES);
  localparam logic [SW-1:0] BUF_BYTES_S   = SW'(BUFFER_BYTES);
  localparam logic [SW-1:0] REGION1_S     = SW'(REGION1_BASE);
  localparam logic [SW-1:0] STRIDE_S      = SW'(BLOCK_STRIDE);
  localparam logic [31:0]   BUF_BYTES_32  = 32'(BUFFER_BYTES);

  // Captured item.
  cmd_t        command_r;
  logic [2:0]  entry_r;
  logic [1:0]  region_r;
  logic [7:0]  frame_r;
  logic [4:0]  bidx_r;
  logic [5:0]  bcount_r;
  logic [6:0]  blen_r;
  logic [9:0]  roff_r;

  // Offset products.
  logic [SW-1:0] start_r, start_nxt;
  logic [PW-1:0] ebase_r, ebase_nxt;

  // Per-entry state.
  logic [7:0]  seen_r     [NUM_ENTRIES];
  logic [31:0] applied_r  [NUM_ENTRIES];
  logic [31:0] expected_r [NUM_ENTRIES];
  logic [1:0]  region_st_r[NUM_ENTRIES];

  // Payload write state.
  logic [PW-1:0] wp_r, wp_nxt;
  logic [6:0]    bl_r, bl_nxt;
  logic          mem_we;

  // Byte store.
  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    rd_data_r;
  logic [PW-1:0] rd_addr;
  logic          rd_ok;
  logic          rd_en;

  // Pending result.
  status_t     res_status_r, res_status_nxt;
  logic [31:0] res_done_r, res_done_nxt;
  logic [31:0] res_valid_r, res_valid_nxt;
  logic [1:0]  res_region_r, res_region_nxt;
  logic        res_rd_r;

  // Execution decode.
  logic          ok;
  logic [IW-1:0] idx;
  logic [31:0]   cur_applied;
  logic          dup;
  logic [SW-1:0] end_off;
  logic          fits;
  logic          apply;
  logic [31:0]   applied_new;
  logic [31:0]   expected_new;

  logic out_valid_r;

  // Capture the item on every accept.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      command_r <= in_command;
      entry_r   <= in_entry_index;
      region_r  <= in_region_select;
      frame_r   <= in_frame;
      bidx_r    <= in_block_index;
      bcount_r  <= in_block_count;
      blen_r    <= in_block_length;
      roff_r    <= in_read_offset;
    end
  end

  // Block start inside the entry and the entry's base in the store.
  always_comb begin
    start_nxt = ((region_r == 2'd0) ? '0 : REGION1_S) + SW'(bidx_r) * STRIDE_S;
    ebase_nxt = PW'(entry_r) * BUF_BYTES_P;
  end

  always_ff @(posedge clk) begin
    if (ctrl.calc) begin
      start_r <= start_nxt;
      ebase_r <= ebase_nxt;
    end
  end

  // Header and command decision for the captured item.
  always_comb begin
    ok          = ({2'b00, entry_r} < NUM_ENTRIES_X);
    idx         = IW'(entry_r);
    cur_applied = applied_r[idx];
    dup         = (seen_r[idx] == frame_r) && cur_applied[bidx_r];
    end_off     = start_r + SW'(blen_r);
    fits        = (end_off <= BUF_BYTES_S);
    apply       = (command_r == CMD_HEADER) && ok && !dup && fits;
    applied_new = cur_applied | (32'd1 << bidx_r);
    // A count of 32 or more gives a full mask.
    expected_new = bcount_r[5] ? '1 : ((32'd1 << bcount_r[4:0]) - 32'd1);
    rd_ok   = ok && ({22'd0, roff_r} < BUF_BYTES_32);
    rd_addr = ebase_r + PW'(roff_r);
    rd_en   = ctrl.exec && (command_r == CMD_READ) && rd_ok;

    res_status_nxt = ST_ACK;
    if (command_r == CMD_HEADER) begin
      if (!ok || (!dup && !fits)) begin
        res_status_nxt = ST_REJECTED;
      end else if (dup) begin
        res_status_nxt = ST_DUPLICATE;
      end else begin
        res_status_nxt = ST_APPLIED;
      end
    end
    res_done_nxt   = '0;
    res_valid_nxt  = '0;
    res_region_nxt = '0;
    if (ok) begin
      res_done_nxt   = apply ? applied_new : cur_applied;
      res_valid_nxt  = apply ? expected_new : expected_r[idx];
      res_region_nxt = apply ? region_r : region_st_r[idx];
    end
  end

  // Entry state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        seen_r[i]      <= '0;
        applied_r[i]   <= '0;
        expected_r[i]  <= '0;
        region_st_r[i] <= '0;
      end
    end else if (ctrl.exec) begin
      if (apply) begin
        applied_r[idx]   <= applied_new;
        expected_r[idx]  <= expected_new;
        region_st_r[idx] <= region_r;
      end
      if ((command_r == CMD_SET_FRAME) && ok) begin
        seen_r[idx] <= frame_r;
      end
    end
  end

  // Pending result fields.
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      res_status_r <= res_status_nxt;
      res_done_r   <= res_done_nxt;
      res_valid_r  <= res_valid_nxt;
      res_region_r <= res_region_nxt;
      res_rd_r     <= (command_r == CMD_READ) && rd_ok;
    end
  end

  // Write pointer and remaining byte count. Any header closes the open block;
  // an applied header opens a new one.
  always_comb begin
    wp_nxt = wp_r;
    bl_nxt = bl_r;
    mem_we = 1'b0;
    if (ctrl.accept && (in_command == CMD_PAYLOAD) && (bl_r != 7'd0)) begin
      mem_we = 1'b1;
      wp_nxt = wp_r + PW'(1);
      bl_nxt = bl_r - 7'd1;
    end
    if (ctrl.exec && (command_r == CMD_HEADER)) begin
      bl_nxt = '0;
      if (apply) begin
        wp_nxt = ebase_r + PW'(start_r);
        bl_nxt = blen_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      bl_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      bl_r <= bl_nxt;
    end
  end

  // Byte store: one write port for payload, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r[AW-1:0]] <= in_data_byte;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr[AW-1:0]];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_status      <= res_status_r;
      out_done_mask   <= res_done_r;
      out_valid_mask  <= res_valid_r;
      out_last_region <= res_region_r;
      out_read_data   <= res_rd_r ? rd_data_r : 8'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// ===== verif/tb_block_reassembly_buffer.sv =====
// Self-checking testbench for block_reassembly_buffer: directed and random command
// streams with random idling on both channels, checked against an in-bench predictor.
// Depends on brb_pkg, brb_in_if, brb_out_if and the block itself.
`timescale 1ns / 1ps

module tb_block_reassembly_buffer;
  import brb_pkg::*;

  localparam int NUM_ENTRIES  = 8;
  localparam int BLOCK_STRIDE = 98;
  localparam int REGION1_BASE = 544;
  localparam int BUFFER_BYTES = 856;
  localparam int STORE_BYTES  = NUM_ENTRIES * BUFFER_BYTES;
  localparam int RANDOM_ITEMS = 600;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int IDLE_PERCENT = 29;

  // One input item as queued, plus two flags used only by the driver.
  typedef struct packed {
    cmd_t       command;
    logic [2:0] entry;
    logic [1:0] region;
    logic [7:0] frame;
    logic [4:0] block_idx;
    logic [5:0] block_cnt;
    logic [6:0] block_len;
    logic [7:0] data;
    logic [9:0] offset;
    logic       pick_offset;  // choose a read offset when the item is driven
    logic       wait_drain;   // hold the item back until no result is pending
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] done_mask;
    logic [31:0] valid_mask;
    logic [1:0]  last_region;
    logic [7:0]  read_data;
  } resp_t;

  logic clk;
  logic rst_n;

  brb_in_if  in_bus ();
  brb_out_if out_bus ();

  block_reassembly_buffer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predicted contents of the block: byte store and per-entry bookkeeping.
  logic [7:0]  byte_store   [STORE_BYTES];
  bit          byte_written [STORE_BYTES];
  logic [7:0]  entry_frame  [NUM_ENTRIES];
  logic [31:0] entry_done   [NUM_ENTRIES];
  logic [31:0] entry_want   [NUM_ENTRIES];
  logic [1:0]  entry_region [NUM_ENTRIES];
  int unsigned fill_addr;
  int unsigned fill_left;

  // Frames issued by set-frame items, tracked while building the stimulus.
  logic [7:0] gen_frame [NUM_ENTRIES];

  req_t  req_queue  [$];
  resp_t resp_queue [$];
  req_t  cur_req;
  bit    req_taken;
  bit    drain_next;
  int    gen_items;
  int    in_count;
  int    out_count;
  int    idle_cycles;
  int    mismatches;
  int    n_applied;
  int    n_duplicate;
  int    n_rejected;
  int    n_reads;
  int    n_bytes;

  // Both channels run without idling while this window of items goes by.
  wire steady = (in_count >= 250) && (in_count < 380);

  // Updates the predicted state for one accepted item; returns 1 when a result is due.
  function automatic bit predict_reassembly(input req_t rq, output resp_t rs);
    int unsigned e;
    int unsigned start;
    e = rq.entry;
    rs = '0;
    if (rq.command == CMD_PAYLOAD) begin
      if (fill_left != 0) begin
        if (fill_addr < STORE_BYTES) begin
          byte_store[fill_addr] = rq.data;
          byte_written[fill_addr] = 1'b1;
        end
        fill_addr++;
        fill_left--;
        n_bytes++;
      end
      return 1'b0;
    end
    case (rq.command)
      CMD_HEADER: begin
        // Any header closes the open block, whatever its outcome.
        fill_left = 0;
        start = (rq.region == 2'd0) ? 0 : REGION1_BASE;
        start += rq.block_idx * BLOCK_STRIDE;
        if (entry_frame[e] == rq.frame && entry_done[e][rq.block_idx]) begin
          rs.status = ST_DUPLICATE;
          n_duplicate++;
        end else if (start + rq.block_len > BUFFER_BYTES) begin
          rs.status = ST_REJECTED;
          n_rejected++;
        end else begin
          fill_addr = e * BUFFER_BYTES + start;
          fill_left = rq.block_len;
          entry_region[e] = rq.region;
          entry_done[e][rq.block_idx] = 1'b1;
          entry_want[e] = (rq.block_cnt >= 6'd32) ? 32'hFFFF_FFFF
                                                  : ((32'd1 << rq.block_cnt) - 32'd1);
          rs.status = ST_APPLIED;
          n_applied++;
        end
      end
      CMD_SET_FRAME: begin
        entry_frame[e] = rq.frame;
        rs.status = ST_ACK;
      end
      default: begin
        rs.status = ST_ACK;
        n_reads++;
        if (rq.offset < BUFFER_BYTES) rs.read_data = byte_store[e * BUFFER_BYTES + rq.offset];
      end
    endcase
    rs.done_mask   = entry_done[e];
    rs.valid_mask  = entry_want[e];
    rs.last_region = entry_region[e];
    return 1'b1;
  endfunction

  // Picks a byte of the entry that has been written, or an offset past the buffer.
  function automatic logic [9:0] pick_read_offset(input logic [2:0] e);
    int unsigned base;
    int unsigned first;
    int unsigned o;
    base = e * BUFFER_BYTES;
    first = $urandom_range(BUFFER_BYTES - 1, 0);
    if ($urandom_range(99, 0) >= 15) begin
      for (int i = 0; i < BUFFER_BYTES; i++) begin
        o = (first + i) % BUFFER_BYTES;
        if (byte_written[base + o]) return o[9:0];
      end
    end
    return 10'($urandom_range(1023, BUFFER_BYTES));
  endfunction

  // An item of the given command with every other field random.
  function automatic req_t noise_item(input cmd_t c);
    logic [63:0] bits;
    req_t rq;
    bits = {$urandom, $urandom};
    rq = bits[$bits(req_t)-1:0];
    rq.command = c;
    rq.pick_offset = (c == CMD_READ);
    rq.wait_drain = 1'b0;
    return rq;
  endfunction

  task automatic add_item(input req_t rq, input bit counted);
    rq.wait_drain = drain_next;
    drain_next = 1'b0;
    if (rq.command == CMD_SET_FRAME) gen_frame[rq.entry] = rq.frame;
    req_queue.push_back(rq);
    if (counted) gen_items++;
  endtask

  task automatic add_header(input int e, input int region, input int frame, input int idx,
                            input int cnt, input int len);
    req_t rq;
    rq = noise_item(CMD_HEADER);
    rq.entry = 3'(e);
    rq.region = 2'(region);
    rq.frame = 8'(frame);
    rq.block_idx = 5'(idx);
    rq.block_cnt = 6'(cnt);
    rq.block_len = 7'(len);
    add_item(rq, 1'b0);
  endtask

  task automatic add_payload(input int data);
    req_t rq;
    rq = noise_item(CMD_PAYLOAD);
    rq.data = 8'(data);
    add_item(rq, 1'b0);
  endtask

  task automatic add_set_frame(input int e, input int frame);
    req_t rq;
    rq = noise_item(CMD_SET_FRAME);
    rq.entry = 3'(e);
    rq.frame = 8'(frame);
    add_item(rq, 1'b0);
  endtask

  task automatic add_read(input int e, input int offset);
    req_t rq;
    rq = noise_item(CMD_READ);
    rq.entry = 3'(e);
    rq.offset = 10'(offset);
    rq.pick_offset = 1'b0;
    add_item(rq, 1'b0);
  endtask

  // A set-frame or read item; a set-frame item mostly carries a frame from 0 to 3.
  task automatic add_side_item();
    req_t rq;
    if ($urandom_range(1, 0) == 1) begin
      rq = noise_item(CMD_SET_FRAME);
      if ($urandom_range(99, 0) < 70) rq.frame = 8'($urandom_range(3, 0));
    end else begin
      rq = noise_item(CMD_READ);
    end
    add_item(rq, 1'b1);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("Mismatch in result %0d, %s: expected %h, got %h", out_count, name, want, got);
    end
  endtask

  // Driver: presents the next queued item at the falling edge once the last one was taken.
  always @(negedge clk) begin : drive_items
    req_t nxt;
    logic drive;
    if (rst_n) begin
      drive = in_bus.valid && !req_taken;
      if (!drive) begin
        req_taken = 1'b0;
        if (req_queue.size() != 0 && !(req_queue[0].wait_drain && resp_queue.size() != 0)
            && (steady || $urandom_range(99, 0) >= IDLE_PERCENT)) begin
          nxt = req_queue.pop_front();
          // All earlier items are accepted here, so the predicted store is current.
          if (nxt.pick_offset) nxt.offset = pick_read_offset(nxt.entry);
          cur_req = nxt;
          drive = 1'b1;
        end
      end
      in_bus.valid         <= drive;
      in_bus.command       <= cur_req.command;
      in_bus.entry_index   <= cur_req.entry;
      in_bus.region_select <= cur_req.region;
      in_bus.frame         <= cur_req.frame;
      in_bus.block_index   <= cur_req.block_idx;
      in_bus.block_count   <= cur_req.block_cnt;
      in_bus.block_length  <= cur_req.block_len;
      in_bus.data_byte     <= cur_req.data;
      in_bus.read_offset   <= cur_req.offset;
    end
  end

  // Result side stalls at random outside the steady window.
  always @(negedge clk) begin : drive_ready
    if (rst_n) out_bus.ready <= steady || ($urandom_range(99, 0) >= IDLE_PERCENT);
  end

  // Monitor: checks results, predicts accepted items and watches for a stalled run.
  always @(posedge clk) begin : watch_channels
    resp_t got;
    resp_t want;
    resp_t rs;
    if (rst_n) begin
      idle_cycles++;
      if (out_bus.valid && out_bus.ready) begin
        idle_cycles = 0;
        out_count++;
        got.status      = out_bus.status;
        got.done_mask   = out_bus.done_mask;
        got.valid_mask  = out_bus.valid_mask;
        got.last_region = out_bus.last_region;
        got.read_data   = out_bus.read_data;
        if (resp_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Unexpected result %0d: status %0d, no result pending", out_count,
                     got.status);
        end else begin
          want = resp_queue.pop_front();
          check_field("status", want.status, got.status);
          check_field("done_mask", want.done_mask, got.done_mask);
          check_field("valid_mask", want.valid_mask, got.valid_mask);
          check_field("last_region", want.last_region, got.last_region);
          check_field("read_data", want.read_data, got.read_data);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        idle_cycles = 0;
        req_taken = 1'b1;
        in_count++;
        if (predict_reassembly(cur_req, rs)) resp_queue.push_back(rs);
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles, %0d results pending", idle_cycles,
                 resp_queue.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : run_test
    req_t rq;
    int seq;
    int kind;
    int n;
    int hi;
    int unsigned room;

    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.command = CMD_HEADER;
    in_bus.entry_index = '0;
    in_bus.region_select = '0;
    in_bus.frame = '0;
    in_bus.block_index = '0;
    in_bus.block_count = '0;
    in_bus.block_length = '0;
    in_bus.data_byte = '0;
    in_bus.read_offset = '0;
    out_bus.ready = 1'b0;
    cur_req = '0;
    req_taken = 1'b0;
    drain_next = 1'b0;
    gen_items = 0;
    in_count = 0;
    out_count = 0;
    idle_cycles = 0;
    mismatches = 0;
    n_applied = 0;
    n_duplicate = 0;
    n_rejected = 0;
    n_reads = 0;
    n_bytes = 0;
    fill_addr = 0;
    fill_left = 0;
    for (int i = 0; i < STORE_BYTES; i++) begin
      byte_store[i] = '0;
      byte_written[i] = 1'b0;
    end
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      entry_frame[i] = '0;
      entry_done[i] = '0;
      entry_want[i] = '0;
      entry_region[i] = '0;
      gen_frame[i] = '0;
    end

    // Directed part: applied, duplicate and rejected headers, open blocks cut
    // short by a new header, zero length, stray payload and reads at the edges.
    add_set_frame(0, 5);
    add_header(0, 0, 5, 0, 0, 3);
    add_payload(8'h00);
    add_payload(8'hFF);
    add_payload(8'hA5);
    add_read(0, 1);
    add_header(0, 0, 5, 0, 0, 3);
    add_header(1, 2, 0, 3, 32, 18);
    add_header(1, 3, 1, 3, 5, 19);
    add_header(2, 0, 9, 8, 63, 0);
    add_header(3, 1, 9, 31, 31, 127);
    add_payload(8'h5A);
    add_header(4, 1, 7, 0, 1, 2);
    add_payload(8'hC3);
    add_header(4, 0, 7, 1, 0, 0);
    add_payload(8'h3C);
    add_read(4, 544);
    add_read(5, 1023);
    add_read(6, BUFFER_BYTES);
    add_set_frame(7, 255);
    add_header(7, 0, 255, 0, 32, 0);
    add_header(7, 0, 255, 0, 32, 0);
    add_read(0, 0);
    add_read(0, 2);

    // Random part: mostly well-formed blocks with random content, plus noise.
    seq = 0;
    while (gen_items < RANDOM_ITEMS) begin
      seq++;
      drain_next = (seq == 60) || (seq == 140);
      kind = $urandom_range(99, 0);
      rq = noise_item(CMD_HEADER);
      if (kind < 60) begin
        // Header that fits, followed by its payload, now and then cut short.
        hi = (rq.region == 2'd0) ? 8 : 3;
        rq.block_idx = 5'($urandom_range(hi, 0));
        room = BUFFER_BYTES - ((rq.region == 2'd0) ? 0 : REGION1_BASE)
               - rq.block_idx * BLOCK_STRIDE;
        if (room > 127) room = 127;
        if ($urandom_range(99, 0) < 15) rq.block_len = 7'($urandom_range(room, 0));
        else rq.block_len = 7'($urandom_range((room < 16) ? room : 16, 0));
        if ($urandom_range(99, 0) < 10) rq.block_cnt = 6'($urandom_range(63, 33));
        else rq.block_cnt = 6'($urandom_range(32, 0));
        if ($urandom_range(1, 0) == 1) rq.frame = gen_frame[rq.entry];
        add_item(rq, 1'b1);
        n = rq.block_len;
        if (kind < 8) n = $urandom_range(n, 0);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(99, 0) < 4) add_side_item();
          add_item(noise_item(CMD_PAYLOAD), 1'b1);
        end
      end else if (kind < 70) begin
        // Header with any fields: mostly rejected for overflow.
        if ($urandom_range(1, 0) == 1) rq.frame = gen_frame[rq.entry];
        add_item(rq, 1'b1);
        n = $urandom_range(3, 0);
        for (int i = 0; i < n; i++) add_item(noise_item(CMD_PAYLOAD), 1'b1);
      end else if (kind < 96) begin
        add_side_item();
      end else begin
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++) add_item(noise_item(CMD_PAYLOAD), 1'b0);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the stimulus to go in and every result to come back.
    while (req_queue.size() != 0 || in_bus.valid || resp_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input items and %0d results, %0d mismatches.", in_count,
             out_count, mismatches);
    $display("Headers: %0d applied, %0d duplicate, %0d rejected; %0d bytes stored, %0d reads.",
             n_applied, n_duplicate, n_rejected, n_bytes, n_reads);
    if (mismatches == 0 && resp_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
